@@ hw/rtl/tac_pkg.sv @@
// ----------------------------------------------------------------------------
// tac_pkg: shared types and constants of the three-axis home-and-center block
// Holds the sequence phase codes, the drive codes and the bundles that
// travel between the sequencer, the sensor decoder and the axis counters.
// ----------------------------------------------------------------------------
package tac_pkg;

  localparam int NUM_AXES = 3;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SEEK     = 3'd1,
    PH_TRAVERSE = 3'd2,
    PH_RETURN   = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  localparam logic [5:0] DRIVE_STOP     = 6'h00;
  localparam logic [5:0] DRIVE_LOW_ALL  = 6'h15;
  localparam logic [5:0] DRIVE_HIGH_ALL = 6'h2A;

  // Low-limit drive bit of each axis: X, Y, Z.
  localparam logic [5:0] AXIS_LOW_BIT [NUM_AXES] = '{6'h01, 6'h04, 6'h10};

  // Active-high view of the sensor bytes, one bit per axis (bit 0 X, 1 Y, 2 Z).
  typedef struct packed {
    logic [NUM_AXES-1:0] lows;
    logic [NUM_AXES-1:0] highs;
    logic [NUM_AXES-1:0] tags;
  } sensor_t;

  // Per-transfer control from the sequencer to every axis counter.
  typedef struct packed {
    logic step;          // an item moves into the result stage this cycle
    logic start;         // clear counts, targets and arrivals
    logic count_en;      // count tag changes (traverse or return)
    logic latch_target;  // traverse ends: target = updated count / 2, count cleared
    logic check;         // return: test the count against the target
  } axis_ctrl_t;

endpackage

@@ hw/rtl/tac_sensor_decode.sv @@
// ----------------------------------------------------------------------------
// tac_sensor_decode: sensor byte decoder
// Inverts the active-low port bytes and gathers the limit and tag bits of
// the three axes into per-axis vectors.
// ----------------------------------------------------------------------------
module tac_sensor_decode
  import tac_pkg::*;
(
  input  logic [7:0] sensor_low,
  input  logic [7:0] sensor_high,
  output sensor_t    sensors
);

  logic [7:0] act_low;
  logic [7:0] act_high;

  assign act_low  = ~sensor_low;
  assign act_high = ~sensor_high;

  assign sensors.lows  = {act_high[0], act_low[3], act_low[0]};
  assign sensors.highs = {act_high[1], act_low[4], act_low[1]};
  assign sensors.tags  = {act_high[2], act_low[5], act_low[2]};

endmodule

@@ hw/rtl/tac_axis_counter.sv @@
// ----------------------------------------------------------------------------
// tac_axis_counter: tag counter of one axis
// Saturating count of tag changes, the center target taken at the end of
// the traverse, and the arrival flag of the return pass.
// ----------------------------------------------------------------------------
module tac_axis_counter
  import tac_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  axis_ctrl_t             ctrl,
  input  logic                   tag_changed,
  output logic [COUNT_WIDTH-1:0] count,
  output logic                   arrived_next
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] target;
  logic                   arrived;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] target_next;
  logic [COUNT_WIDTH-1:0] count_inc;

  assign count_inc = count + COUNT_WIDTH'(tag_changed && (count != COUNT_MAX));

  always_comb begin
    count_next   = count;
    target_next  = target;
    arrived_next = arrived;
    if (ctrl.start) begin
      count_next   = '0;
      target_next  = '0;
      arrived_next = 1'b0;
    end else if (ctrl.latch_target) begin
      // The arrival test runs at once against a cleared count.
      target_next  = count_inc >> 1;
      count_next   = '0;
      arrived_next = ((count_inc >> 1) == '0);
    end else if (ctrl.count_en) begin
      count_next = count_inc;
      if (ctrl.check && !arrived && (count_inc >= target)) begin
        arrived_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      target  <= '0;
      arrived <= 1'b0;
    end else if (ctrl.step) begin
      count   <= count_next;
      target  <= target_next;
      arrived <= arrived_next;
    end
  end

endmodule

@@ hw/rtl/three_axis_home_and_center.sv @@
// ----------------------------------------------------------------------------
// three_axis_home_and_center: homing and centering sequencer for three axes
// Seeks the low limits, counts tag changes on the way to the high limits,
// then drives back and stops each axis at half of its counted span.
// ----------------------------------------------------------------------------
// A user first wants to know this: the block takes one transfer per clock
// cycle on the sample channel while the result channel is not stalled, and
// each transfer yields exactly one result transfer, held first in the input
// register and then in the result stage, the block's two register stages; the
// per-sample work is a decode, three saturating counter updates, a compare
// against the center targets and the phase decision, all combinational.
// A command of 1 starts (or restarts) the sequence and ignores the sensor
// bytes; a command of 0 is a sensor sample. The result shows the drive code,
// the phase and the three tag counts after that item. The drive, phase and
// count registers are the block's state and also hold the result on the
// result port, so a stalled result never changes: the next item enters the
// result stage only when the result is taken or the stage is empty. While
// the result stage is stalled the input register still takes one sample.
// Counts saturate at 2^COUNT_WIDTH - 1; the count ports show their low 16
// bits, zero-extended when COUNT_WIDTH is below 16.
// ----------------------------------------------------------------------------
module three_axis_home_and_center
  import tac_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Sample channel
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic        command,
  input  logic [7:0]  sensor_low,
  input  logic [7:0]  sensor_high,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [5:0]  drive,
  output logic [2:0]  phase,
  output logic [15:0] count_x,
  output logic [15:0] count_y,
  output logic [15:0] count_z
);

  localparam int SHOW_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

  // Input register stage.
  logic       in_full;
  logic       in_command;
  logic [7:0] in_sensor_low;
  logic [7:0] in_sensor_high;

  // Sequencer state; these registers also form the result.
  phase_t              phase_reg;
  logic [5:0]          drive_reg;
  logic [NUM_AXES-1:0] previous_tags;

  phase_t              phase_reg_next;
  logic [5:0]          drive_reg_next;
  logic [NUM_AXES-1:0] previous_tags_next;

  logic                result_free;
  logic                step;
  sensor_t             sensors;
  axis_ctrl_t          axis_ctrl;
  logic [NUM_AXES-1:0] tag_changed;
  logic [NUM_AXES-1:0] arrived_next;
  logic [5:0]          return_drive;
  logic [COUNT_WIDTH-1:0] counts [NUM_AXES];
  logic [15:0]         shown   [NUM_AXES];

  // The result stage can take an item when it is empty or its result is
  // being taken this cycle. The input register moves on at the same time.
  assign result_free  = !result_valid || !result_stall;
  assign step         = in_full && result_free;
  assign sample_stall = in_full && !result_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!sample_stall) begin
      in_full <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_command     <= command;
      in_sensor_low  <= sensor_low;
      in_sensor_high <= sensor_high;
    end
  end

  tac_sensor_decode u_decode (
    .sensor_low  (in_sensor_low),
    .sensor_high (in_sensor_high),
    .sensors     (sensors)
  );

  assign tag_changed = sensors.tags ^ previous_tags;

  // Controls for the axis counters, decoded from the phase and the sample.
  always_comb begin
    axis_ctrl.step         = step;
    axis_ctrl.start        = in_command;
    axis_ctrl.count_en     = !in_command &&
                             ((phase_reg == PH_TRAVERSE) || (phase_reg == PH_RETURN));
    axis_ctrl.latch_target = !in_command && (phase_reg == PH_TRAVERSE) &&
                             (&sensors.highs);
    axis_ctrl.check        = !in_command && (phase_reg == PH_RETURN);
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    tac_axis_counter #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_axis (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (axis_ctrl),
      .tag_changed  (tag_changed[a]),
      .count        (counts[a]),
      .arrived_next (arrived_next[a])
    );

    always_comb begin
      shown[a]             = '0;
      shown[a][SHOW_W-1:0] = counts[a][SHOW_W-1:0];
    end
  end

  // On the way back an axis keeps its low drive bit until it has arrived.
  always_comb begin
    return_drive = DRIVE_LOW_ALL;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (arrived_next[a]) begin
        return_drive = return_drive & ~AXIS_LOW_BIT[a];
      end
    end
  end

  always_comb begin
    phase_reg_next     = phase_reg;
    drive_reg_next     = drive_reg;
    previous_tags_next = previous_tags;
    if (in_command) begin
      phase_reg_next = PH_SEEK;
      drive_reg_next = DRIVE_LOW_ALL;
    end else begin
      case (phase_reg)
        PH_SEEK: begin
          previous_tags_next = sensors.tags;
          if (&sensors.lows) begin
            phase_reg_next = PH_TRAVERSE;
            drive_reg_next = DRIVE_HIGH_ALL;
          end
        end
        PH_TRAVERSE: begin
          previous_tags_next = sensors.tags;
          if (&sensors.highs) begin
            // Entering the return pass; an axis with a zero target has
            // already arrived, and if all have, the sequence is over.
            if (&arrived_next) begin
              phase_reg_next = PH_DONE;
              drive_reg_next = DRIVE_STOP;
            end else begin
              phase_reg_next = PH_RETURN;
              drive_reg_next = return_drive;
            end
          end
        end
        PH_RETURN: begin
          previous_tags_next = sensors.tags;
          if (&arrived_next) begin
            phase_reg_next = PH_DONE;
            drive_reg_next = DRIVE_STOP;
          end else begin
            drive_reg_next = return_drive;
          end
        end
        default: begin
          // Idle and done: samples leave the state as it is.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      drive_reg     <= DRIVE_STOP;
      previous_tags <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (step) begin
        phase_reg     <= phase_reg_next;
        drive_reg     <= drive_reg_next;
        previous_tags <= previous_tags_next;
      end
      if (result_free) begin
        result_valid <= in_full;
      end
    end
  end

  assign drive   = drive_reg;
  assign phase   = phase_reg;
  assign count_x = shown[0];
  assign count_y = shown[1];
  assign count_z = shown[2];

endmodule
